// File: rtl/vsl_pkg.sv
// shared constants for the voltage sleep ladder
`timescale 1ns / 1ps
`default_nettype none

package vsl_pkg;

   localparam int TIME_WIDTH_DEFAULT = 32;

   localparam int MV_WIDTH    = 16;
   localparam int STAMP_WIDTH = 32;
   localparam int DELAY_WIDTH = 31;
   localparam int CODE_WIDTH  = 2;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // ladder modes
   localparam logic [CODE_WIDTH-1:0] MODE_NORMAL   = 2'd0;
   localparam logic [CODE_WIDTH-1:0] MODE_LOW      = 2'd1;
   localparam logic [CODE_WIDTH-1:0] MODE_SLEEPING = 2'd2;
   localparam logic [CODE_WIDTH-1:0] MODE_PENDING  = 2'd3;

   // actions
   localparam logic [CODE_WIDTH-1:0] ACT_NONE     = 2'd0;
   localparam logic [CODE_WIDTH-1:0] ACT_SLEEP    = 2'd1;
   localparam logic [CODE_WIDTH-1:0] ACT_PERIODIC = 2'd2;
   localparam logic [CODE_WIDTH-1:0] ACT_REBOOT   = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SLEEP_MV         = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_WAKE_MV          = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CRITICAL_MV      = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LOW_DELAY_MS     = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_WAKE_INTERVAL_MS = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_STABLE_MS        = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PERIODIC_ENABLE  = 3'd6;

endpackage

`default_nettype wire

// File: rtl/vsl_channels.sv
// request, response and register write channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface vsl_req_if;
   logic                         valid;
   logic                         ready;
   logic [vsl_pkg::MV_WIDTH-1:0]    voltage_mv;
   logic [vsl_pkg::STAMP_WIDTH-1:0] time_ms;

   modport source (output valid, output voltage_mv, output time_ms, input ready);
   modport sink   (input valid, input voltage_mv, input time_ms, output ready);
endinterface

interface vsl_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [vsl_pkg::CODE_WIDTH-1:0] action;
   logic [vsl_pkg::CODE_WIDTH-1:0] mode;

   modport source (output valid, output action, output mode, input ready);
   modport sink   (input valid, input action, input mode, output ready);
endinterface

interface vsl_csr_if;
   logic                               valid;
   logic                               ready;
   logic [vsl_pkg::CSR_IDX_WIDTH-1:0]  index;
   logic [vsl_pkg::CSR_DATA_WIDTH-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/voltage_sleep_ladder.sv
// voltage sleep ladder: mode ladder with hysteresis and wrap-safe deadlines
//
//   channel   dir   payload                         handshake
//   req_ch    in    voltage_mv[15:0], time_ms[31:0] valid / ready
//   rsp_ch    out   action[1:0], mode[1:0]          valid / ready
//   csr_ch    in    index[2:0], data[31:0]          valid / ready (always ready)
//
// one request per cycle sustained while rsp_ch takes responses; a response shows after its
// request is taken and passes the input register, then the response register
// the mode and deadlines update in the cycle a request moves from the input
// register to the response register
// a stalled response holds both stages; req_ch.ready drops only when both are full
// reset (synchronous) clears the mode, deadlines, valid flags and configuration
`timescale 1ns / 1ps
`default_nettype none

module voltage_sleep_ladder #(
   parameter int TIME_WIDTH = vsl_pkg::TIME_WIDTH_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   vsl_req_if.sink    req_ch,
   vsl_rsp_if.source  rsp_ch,
   vsl_csr_if.sink    csr_ch
);

   // configuration registers
   logic [vsl_pkg::MV_WIDTH-1:0]    sleep_mv_ff;
   logic [vsl_pkg::MV_WIDTH-1:0]    wake_mv_ff;
   logic [vsl_pkg::MV_WIDTH-1:0]    critical_mv_ff;
   logic [vsl_pkg::DELAY_WIDTH-1:0] low_delay_ff;
   logic [vsl_pkg::DELAY_WIDTH-1:0] wake_interval_ff;
   logic [vsl_pkg::DELAY_WIDTH-1:0] stable_ff;
   logic                            periodic_enable_ff;

   // input register
   logic                            in_valid_ff;
   logic [vsl_pkg::MV_WIDTH-1:0]    in_volt_ff;
   logic [vsl_pkg::STAMP_WIDTH-1:0] in_time_ff;

   // ladder state
   logic [vsl_pkg::CODE_WIDTH-1:0] mode_ff, mode_in;
   logic [TIME_WIDTH-1:0]          low_dl_ff, low_dl_in;
   logic [TIME_WIDTH-1:0]          stable_dl_ff, stable_dl_in;
   logic [TIME_WIDTH-1:0]          periodic_dl_ff, periodic_dl_in;

   // response register
   logic                           out_valid_ff;
   logic [vsl_pkg::CODE_WIDTH-1:0] out_action_ff, out_action_in;
   logic [vsl_pkg::CODE_WIDTH-1:0] out_mode_ff;

   logic                  advance;
   logic                  step;
   logic                  take;
   logic [TIME_WIDTH-1:0] now;
   logic [TIME_WIDTH-1:0] low_diff, stable_diff, periodic_diff;
   logic                  low_due, stable_due, periodic_due;
   logic                  volt_good;

   assign advance = !out_valid_ff || rsp_ch.ready;
   assign step    = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;
   assign take    = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.action = out_action_ff;
   assign rsp_ch.mode   = out_mode_ff;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sleep_mv_ff        <= '0;
         wake_mv_ff         <= '0;
         critical_mv_ff     <= '0;
         low_delay_ff       <= '0;
         wake_interval_ff   <= '0;
         stable_ff          <= '0;
         periodic_enable_ff <= 1'b0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            vsl_pkg::CSR_SLEEP_MV:
               sleep_mv_ff <= csr_ch.data[vsl_pkg::MV_WIDTH-1:0];
            vsl_pkg::CSR_WAKE_MV:
               wake_mv_ff <= csr_ch.data[vsl_pkg::MV_WIDTH-1:0];
            vsl_pkg::CSR_CRITICAL_MV:
               critical_mv_ff <= csr_ch.data[vsl_pkg::MV_WIDTH-1:0];
            vsl_pkg::CSR_LOW_DELAY_MS:
               low_delay_ff <= csr_ch.data[vsl_pkg::DELAY_WIDTH-1:0];
            vsl_pkg::CSR_WAKE_INTERVAL_MS:
               wake_interval_ff <= csr_ch.data[vsl_pkg::DELAY_WIDTH-1:0];
            vsl_pkg::CSR_STABLE_MS:
               stable_ff <= csr_ch.data[vsl_pkg::DELAY_WIDTH-1:0];
            vsl_pkg::CSR_PERIODIC_ENABLE:
               periodic_enable_ff <= csr_ch.data[0];
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_volt_ff <= req_ch.voltage_mv;
         in_time_ff <= req_ch.time_ms;
      end
   end

   // deadline reached when now - deadline is not negative
   assign now           = TIME_WIDTH'(in_time_ff);
   assign low_diff      = now - low_dl_ff;
   assign stable_diff   = now - stable_dl_ff;
   assign periodic_diff = now - periodic_dl_ff;
   assign low_due       = !low_diff[TIME_WIDTH-1];
   assign stable_due    = !stable_diff[TIME_WIDTH-1];
   assign periodic_due  = !periodic_diff[TIME_WIDTH-1];
   assign volt_good     = in_volt_ff >= wake_mv_ff;

   always_comb begin
      mode_in        = mode_ff;
      low_dl_in      = low_dl_ff;
      stable_dl_in   = stable_dl_ff;
      periodic_dl_in = periodic_dl_ff;
      out_action_in  = vsl_pkg::ACT_NONE;
      unique case (mode_ff)
         vsl_pkg::MODE_NORMAL: begin
            if (in_volt_ff < sleep_mv_ff) begin
               mode_in   = vsl_pkg::MODE_LOW;
               low_dl_in = now + TIME_WIDTH'(low_delay_ff);
            end
         end
         vsl_pkg::MODE_LOW: begin
            if (volt_good) begin
               mode_in = vsl_pkg::MODE_NORMAL;
            end else if (low_due) begin
               mode_in        = vsl_pkg::MODE_SLEEPING;
               periodic_dl_in = now + TIME_WIDTH'(wake_interval_ff);
               out_action_in  = vsl_pkg::ACT_SLEEP;
            end
         end
         vsl_pkg::MODE_SLEEPING: begin
            if (volt_good) begin
               mode_in      = vsl_pkg::MODE_PENDING;
               stable_dl_in = now + TIME_WIDTH'(stable_ff);
            end else if (periodic_enable_ff && (in_volt_ff > critical_mv_ff)
                         && periodic_due) begin
               // deadline left as is, so this repeats until the mode moves
               out_action_in = vsl_pkg::ACT_PERIODIC;
            end
         end
         default: begin
            if (!volt_good) begin
               mode_in = vsl_pkg::MODE_SLEEPING;
            end else if (stable_due) begin
               out_action_in = vsl_pkg::ACT_REBOOT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= vsl_pkg::MODE_NORMAL;
         low_dl_ff      <= '0;
         stable_dl_ff   <= '0;
         periodic_dl_ff <= '0;
      end else if (step) begin
         mode_ff        <= mode_in;
         low_dl_ff      <= low_dl_in;
         stable_dl_ff   <= stable_dl_in;
         periodic_dl_ff <= periodic_dl_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_action_ff <= out_action_in;
         out_mode_ff   <= mode_in;
      end
   end

`ifndef SYNTHESIS
   a_sleep_mode: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_action_ff == vsl_pkg::ACT_SLEEP)
      |-> out_mode_ff == vsl_pkg::MODE_SLEEPING)
      else $error("enter sleep response without sleeping mode");

   a_periodic_mode: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_action_ff == vsl_pkg::ACT_PERIODIC)
      |-> out_mode_ff == vsl_pkg::MODE_SLEEPING)
      else $error("periodic wake response outside sleeping mode");

   a_reboot_mode: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_action_ff == vsl_pkg::ACT_REBOOT)
      |-> out_mode_ff == vsl_pkg::MODE_PENDING)
      else $error("wake reboot response outside wake pending mode");

   a_normal_exit: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == vsl_pkg::MODE_NORMAL && step && mode_in != vsl_pkg::MODE_NORMAL)
      |=> mode_ff == vsl_pkg::MODE_LOW)
      else $error("normal mode left for a mode other than low");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(mode_ff))
      else $error("ladder mode moved without a request");
`endif

endmodule

`default_nettype wire

// File: sim/testbench.sv
// testbench for the voltage sleep ladder: scoreboard class, stimulus tasks and top
`timescale 1ns / 1ps
`default_nettype none

module testbench;

   localparam int TW             = vsl_pkg::TIME_WIDTH_DEFAULT;
   localparam int PHASE_ITEMS    = 120;
   localparam int HOLD_CYCLES    = 60;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [vsl_pkg::CSR_IDX_WIDTH-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [vsl_pkg::CODE_WIDTH-1:0] action;
      logic [vsl_pkg::CODE_WIDTH-1:0] mode;
   } ladder_result_type;

   // mirrors the ladder and checks responses in order
   class ladder_scoreboard_type;
      logic [vsl_pkg::MV_WIDTH-1:0]    sleep_mv, wake_mv, critical_mv;
      logic [vsl_pkg::DELAY_WIDTH-1:0] low_delay, wake_interval, stable_span;
      logic                            periodic_on;
      logic [vsl_pkg::CODE_WIDTH-1:0]  mode;
      logic [TW-1:0]                   low_due, stable_due, periodic_due;
      ladder_result_type               expected_q[$];
      int                              mismatches;
      int                              results_seen;
      int                              action_seen[4];
      int                              pending_seen;

      function new();
         sleep_mv = '0; wake_mv = '0; critical_mv = '0;
         low_delay = '0; wake_interval = '0; stable_span = '0;
         periodic_on = 1'b0;
         mode = vsl_pkg::MODE_NORMAL;
         low_due = '0; stable_due = '0; periodic_due = '0;
         mismatches = 0;
         results_seen = 0;
         pending_seen = 0;
         foreach (action_seen[i]) action_seen[i] = 0;
      endfunction

      // signed distance from the deadline decides, so wrap is harmless
      function bit reached(logic [TW-1:0] deadline, logic [TW-1:0] now);
         logic [TW-1:0] diff;
         diff = now - deadline;
         return !diff[TW-1];
      endfunction

      function void note_write(logic [vsl_pkg::CSR_IDX_WIDTH-1:0] idx,
                               logic [vsl_pkg::CSR_DATA_WIDTH-1:0] value);
         case (idx)
            vsl_pkg::CSR_SLEEP_MV:         sleep_mv      = value[vsl_pkg::MV_WIDTH-1:0];
            vsl_pkg::CSR_WAKE_MV:          wake_mv       = value[vsl_pkg::MV_WIDTH-1:0];
            vsl_pkg::CSR_CRITICAL_MV:      critical_mv   = value[vsl_pkg::MV_WIDTH-1:0];
            vsl_pkg::CSR_LOW_DELAY_MS:     low_delay     = value[vsl_pkg::DELAY_WIDTH-1:0];
            vsl_pkg::CSR_WAKE_INTERVAL_MS: wake_interval = value[vsl_pkg::DELAY_WIDTH-1:0];
            vsl_pkg::CSR_STABLE_MS:        stable_span   = value[vsl_pkg::DELAY_WIDTH-1:0];
            vsl_pkg::CSR_PERIODIC_ENABLE:  periodic_on   = value[0];
            default: ;
         endcase
      endfunction

      function void note_sample(logic [vsl_pkg::MV_WIDTH-1:0] v,
                                logic [vsl_pkg::STAMP_WIDTH-1:0] stamp);
         ladder_result_type r;
         logic [TW-1:0]     now;
         now = stamp[TW-1:0];
         r.action = vsl_pkg::ACT_NONE;
         case (mode)
            vsl_pkg::MODE_NORMAL: begin
               if (v < sleep_mv) begin
                  mode = vsl_pkg::MODE_LOW;
                  low_due = now + TW'(low_delay);
               end
            end
            vsl_pkg::MODE_LOW: begin
               if (v >= wake_mv) begin
                  mode = vsl_pkg::MODE_NORMAL;
               end else if (reached(low_due, now)) begin
                  mode = vsl_pkg::MODE_SLEEPING;
                  periodic_due = now + TW'(wake_interval);
                  r.action = vsl_pkg::ACT_SLEEP;
               end
            end
            vsl_pkg::MODE_SLEEPING: begin
               if (v >= wake_mv) begin
                  mode = vsl_pkg::MODE_PENDING;
                  stable_due = now + TW'(stable_span);
               end else if (periodic_on && v > critical_mv && reached(periodic_due, now)) begin
                  // periodic deadline is never re-armed
                  r.action = vsl_pkg::ACT_PERIODIC;
               end
            end
            default: begin
               if (v < wake_mv) begin
                  mode = vsl_pkg::MODE_SLEEPING;
               end else if (reached(stable_due, now)) begin
                  r.action = vsl_pkg::ACT_REBOOT;
               end
            end
         endcase
         r.mode = mode;
         expected_q.push_back(r);
      endfunction

      function void check_result(logic [vsl_pkg::CODE_WIDTH-1:0] action,
                                 logic [vsl_pkg::CODE_WIDTH-1:0] md);
         ladder_result_type want;
         results_seen++;
         if (expected_q.size() == 0) begin
            $error("response with no request waiting: action %0d mode %0d", action, md);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         if (action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, action);
            mismatches++;
         end
         if (md !== want.mode) begin
            $error("mode: expected %0d, got %0d", want.mode, md);
            mismatches++;
         end
         action_seen[want.action]++;
         if (want.mode == vsl_pkg::MODE_PENDING) pending_seen++;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   vsl_req_if req_ch ();
   vsl_rsp_if rsp_ch ();
   vsl_csr_if csr_ch ();

   voltage_sleep_ladder uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   ladder_scoreboard_type sb = new();

   bit                               steady = 1'b0;
   int                               offered = 0;
   int                               settings = 0;
   int                               quiet_cycles = 0;
   logic [vsl_pkg::STAMP_WIDTH-1:0]  now_ms = '0;
   logic [vsl_pkg::MV_WIDTH-1:0]     cfg_wake = '0, cfg_crit = '0;
   logic [vsl_pkg::STAMP_WIDTH-1:0]  cfg_interval = '0, cfg_stable = '0;

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [vsl_pkg::STAMP_WIDTH-1:0] pick_step(
         logic [vsl_pkg::STAMP_WIDTH-1:0] span);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return span;
         2: return span + 32'd1;
         default: return $urandom_range(0, span / 2 + 1);
      endcase
   endfunction

   function automatic logic [vsl_pkg::MV_WIDTH-1:0] sag_voltage();
      logic [vsl_pkg::MV_WIDTH-1:0] top;
      top = (cfg_wake == '0) ? '0 : cfg_wake - 16'd1;
      case ($urandom_range(0, 3))
         0: return (cfg_crit < top) ? cfg_crit : top;
         1: return (cfg_crit < top) ? cfg_crit + 16'd1 : top;
         2: return top;
         default: return 16'($urandom_range(0, top));
      endcase
   endfunction

   function automatic logic [vsl_pkg::MV_WIDTH-1:0] good_voltage();
      case ($urandom_range(0, 3))
         0: return cfg_wake;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(cfg_wake, 16'hFFFF));
      endcase
   endfunction

   task automatic offer(input logic [vsl_pkg::MV_WIDTH-1:0] v,
                        input logic [vsl_pkg::STAMP_WIDTH-1:0] stamp);
      int gap;
      req_ch.valid      <= 1'b1;
      req_ch.voltage_mv <= v;
      req_ch.time_ms    <= stamp;
      do @(posedge clock); while (!req_ch.ready);
      offered++;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.results_seen < offered) @(posedge clock);
   endtask

   task automatic csr_write(input logic [vsl_pkg::CSR_IDX_WIDTH-1:0] idx,
                            input logic [vsl_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   // upper data bits carry junk, the block must drop them
   task automatic apply_setting(input logic [vsl_pkg::MV_WIDTH-1:0] s, w, c,
                                input logic [vsl_pkg::DELAY_WIDTH-1:0] ld, wi, st,
                                input logic pe);
      cfg_wake = w;
      cfg_crit = c;
      cfg_interval = {1'b0, wi};
      cfg_stable = {1'b0, st};
      csr_write(vsl_pkg::CSR_SLEEP_MV, {16'($urandom), s});
      csr_write(vsl_pkg::CSR_WAKE_MV, {16'($urandom), w});
      csr_write(vsl_pkg::CSR_CRITICAL_MV, {16'($urandom), c});
      csr_write(vsl_pkg::CSR_LOW_DELAY_MS, {1'($urandom), ld});
      csr_write(vsl_pkg::CSR_WAKE_INTERVAL_MS, {1'($urandom), wi});
      csr_write(vsl_pkg::CSR_STABLE_MS, {1'($urandom), st});
      csr_write(vsl_pkg::CSR_PERIODIC_ENABLE, {31'($urandom), pe});
      csr_write(CSR_UNUSED, $urandom);
      csr_ch.valid <= 1'b0;
      settings++;
   endtask

   // one sag while asleep, a recovery, then waiting out the stable time
   task automatic sleep_cycle();
      int n;
      n = $urandom_range(1, 5);
      repeat (n) begin
         now_ms += pick_step(cfg_interval);
         offer(sag_voltage(), now_ms);
      end
      now_ms += pick_step(cfg_stable);
      offer(good_voltage(), now_ms);
      n = $urandom_range(1, 6);
      repeat (n) begin
         now_ms += pick_step(cfg_stable);
         offer(($urandom_range(0, 7) == 0) ? sag_voltage() : good_voltage(), now_ms);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) sb.note_write(csr_ch.index, csr_ch.data);
         if (req_ch.valid && req_ch.ready) sb.note_sample(req_ch.voltage_mv, req_ch.time_ms);
         if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.action, rsp_ch.mode);
         if ((csr_ch.valid && csr_ch.ready) || (req_ch.valid && req_ch.ready) ||
             (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else if (++quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // response side; one long hold-off while requests keep coming
   initial begin : response_sink
      int burst;
      int gap;
      bit held;
      held = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (!held && sb.results_seen >= 300 && req_ch.valid) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         burst = $urandom_range(1, 12);
         rsp_ch.ready <= 1'b1;
         repeat (burst) @(posedge clock);
         gap = steady ? 0 : pick_gap();
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [vsl_pkg::STAMP_WIDTH-1:0] t0;
      int                              phase_end;
      req_ch.valid      <= 1'b0;
      req_ch.voltage_mv <= '0;
      req_ch.time_ms    <= '0;
      csr_ch.valid      <= 1'b0;
      csr_ch.index      <= '0;
      csr_ch.data       <= '0;
      rsp_ch.ready      <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // all thresholds zero after reset: nothing leaves normal
      offer(16'h0000, 32'h0000_0000);
      offer(16'hFFFF, 32'hFFFF_FFFF);
      drain();
      apply_setting(16'd3300, 16'd3600, 16'd3000, 31'd100, 31'd500, 31'd200, 1'b1);

      t0 = 32'hFFFF_FFC0;
      offer(16'hFFFF, t0);
      offer(16'd3300, t0 + 1);                    // equal to sleep level stays normal
      offer(16'd3299, t0 + 2);
      offer(16'd3600, t0 + 3);                    // recovery from low at the wake level
      offer(16'd0, t0 + 4);
      offer(16'd3599, t0 + 104 + 32'h8000_0000);  // half a ring away counts as not yet
      offer(16'd3599, t0 + 103);
      offer(16'd3599, t0 + 104);                  // sleep entry across the time wrap
      offer(16'd3000, t0 + 700);                  // at critical level, no wake
      offer(16'd3001, t0 + 603);
      offer(16'd3001, t0 + 604);
      offer(16'd3599, t0 + 605);                  // periodic wake repeats
      offer(16'd2999, t0 + 606);
      offer(16'd3600, t0 + 610);
      offer(16'hFFFF, t0 + 809);
      offer(16'd3599, t0 + 810);                  // dip while pending
      offer(16'd3001, t0 + 811);                  // old periodic deadline still holds
      offer(16'd3600, t0 + 900);
      offer(16'd3600, t0 + 1100);
      offer(16'hFFFF, t0 + 1100 + 32'h7FFF_FFFF); // reboot repeats
      offer(16'd40000, t0 + 1100 + 32'h8000_0000);
      offer(16'd0, t0 + 1200);
      now_ms = t0 + 1200;

      // no path leads back to normal once asleep, so the random part
      // works the sleeping and wake pending states
      for (int p = 0; p < 7; p++) begin
         drain();
         case (p)
            0: apply_setting(16'd3300, 16'd3600, 16'd3000, 31'd100, 31'd500, 31'd200, 1'b1);
            1: apply_setting(16'd3600, 16'd3300, 16'd3400, 31'd0, 31'd0, 31'd0, 1'b1);
            2: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                             31'h7FFF_FFFF, 1'b1);
            3: apply_setting(16'h0000, 16'h0000, 16'h0000, 31'd0, 31'd0, 31'd0, 1'b0);
            4: apply_setting(16'($urandom), 16'($urandom), 16'($urandom),
                             31'($urandom_range(0, 1000)), 31'($urandom_range(0, 1000)),
                             31'($urandom_range(0, 1000)), 1'($urandom));
            5: apply_setting(16'($urandom), 16'($urandom), 16'($urandom),
                             31'($urandom), 31'($urandom), 31'($urandom), 1'b1);
            default: apply_setting(16'd1200, 16'd1500, 16'd1000, 31'd20, 31'd60, 31'd40, 1'b1);
         endcase
         steady = (p == 1) || (p > 1 && $urandom_range(0, 3) == 0);
         phase_end = offered + PHASE_ITEMS;
         while (offered < phase_end) begin
            if ($urandom_range(0, 4) == 0) begin
               now_ms = $urandom;
               offer(16'($urandom), now_ms);
            end else begin
               sleep_cycle();
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      $display("covered %0d requests under %0d register settings, %0d responses checked",
               offered, settings, sb.results_seen);
      $display("actions: none %0d, sleep %0d, periodic wake %0d, reboot %0d; %0d while pending",
               sb.action_seen[vsl_pkg::ACT_NONE], sb.action_seen[vsl_pkg::ACT_SLEEP],
               sb.action_seen[vsl_pkg::ACT_PERIODIC], sb.action_seen[vsl_pkg::ACT_REBOOT],
               sb.pending_seen);
      if (sb.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
